// ===== src/hqg_pkg.sv =====
// hqg_pkg: shared types, constants and helper functions of the Hurwitz quaternion gcd unit
// no dependencies; used by hqg_mul, hqg_div, hurwitz_quaternion_gcd_unit and the testbench
package hqg_pkg;

   localparam int COORD_BITS    = 24;
   localparam int OUT_BITS      = 48;
   localparam int WORD_BITS     = 64;
   localparam int EUCLID_ROUNDS = 64;
   localparam int ROUND_BITS    = $clog2(EUCLID_ROUNDS + 1);

   localparam logic [1:0] OP_PRODUCT  = 2'd0;
   localparam logic [1:0] OP_QUOTIENT = 2'd1;
   localparam logic [1:0] OP_GCLD     = 2'd2;
   localparam logic [1:0] OP_INVALID  = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef word_type [3:0] quat_type;

   typedef struct packed {
      logic [1:0]                   operation;
      logic signed [COORD_BITS-1:0] a_real;
      logic signed [COORD_BITS-1:0] a_i;
      logic signed [COORD_BITS-1:0] a_j;
      logic signed [COORD_BITS-1:0] a_k;
      logic signed [COORD_BITS-1:0] b_real;
      logic signed [COORD_BITS-1:0] b_i;
      logic signed [COORD_BITS-1:0] b_j;
      logic signed [COORD_BITS-1:0] b_k;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] res_real;
      logic signed [OUT_BITS-1:0] res_i;
      logic signed [OUT_BITS-1:0] res_j;
      logic signed [OUT_BITS-1:0] res_k;
      logic                       status;
   } rsp_type;

   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      word_type prod;
   } mul_rsp_type;

   typedef struct packed {
      logic     start;
      word_type num;
      word_type den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quo;
      word_type rem;
   } div_rsp_type;

   typedef struct packed {
      logic [1:0] ai;
      logic [1:0] bi;
      logic [1:0] zi;
      logic       neg;
   } term_type;

   // terms of the quaternion product, one per multiply
   function automatic term_type prod_term(input logic [3:0] idx);
      term_type t;
      case (idx)
         4'd0:    t = '{ai: 2'd0, bi: 2'd0, zi: 2'd0, neg: 1'b0};
         4'd1:    t = '{ai: 2'd1, bi: 2'd1, zi: 2'd0, neg: 1'b1};
         4'd2:    t = '{ai: 2'd2, bi: 2'd2, zi: 2'd0, neg: 1'b1};
         4'd3:    t = '{ai: 2'd3, bi: 2'd3, zi: 2'd0, neg: 1'b1};
         4'd4:    t = '{ai: 2'd0, bi: 2'd1, zi: 2'd1, neg: 1'b0};
         4'd5:    t = '{ai: 2'd1, bi: 2'd0, zi: 2'd1, neg: 1'b0};
         4'd6:    t = '{ai: 2'd2, bi: 2'd3, zi: 2'd1, neg: 1'b0};
         4'd7:    t = '{ai: 2'd3, bi: 2'd2, zi: 2'd1, neg: 1'b1};
         4'd8:    t = '{ai: 2'd0, bi: 2'd2, zi: 2'd2, neg: 1'b0};
         4'd9:    t = '{ai: 2'd2, bi: 2'd0, zi: 2'd2, neg: 1'b0};
         4'd10:   t = '{ai: 2'd3, bi: 2'd1, zi: 2'd2, neg: 1'b0};
         4'd11:   t = '{ai: 2'd1, bi: 2'd3, zi: 2'd2, neg: 1'b1};
         4'd12:   t = '{ai: 2'd0, bi: 2'd3, zi: 2'd3, neg: 1'b0};
         4'd13:   t = '{ai: 2'd3, bi: 2'd0, zi: 2'd3, neg: 1'b0};
         4'd14:   t = '{ai: 2'd1, bi: 2'd2, zi: 2'd3, neg: 1'b0};
         4'd15:   t = '{ai: 2'd2, bi: 2'd1, zi: 2'd3, neg: 1'b1};
         default: t = '{ai: 2'd0, bi: 2'd0, zi: 2'd0, neg: 1'b0};
      endcase
      return t;
   endfunction

   // truncating halving and quartering
   function automatic word_type half_trunc(input word_type w);
      word_type t;
      t = w + {{(WORD_BITS-1){1'b0}}, w[WORD_BITS-1]};
      return {t[WORD_BITS-1], t[WORD_BITS-1:1]};
   endfunction

   function automatic word_type quarter_trunc(input word_type w);
      word_type t;
      t = w + {{(WORD_BITS-2){1'b0}}, {2{w[WORD_BITS-1]}}};
      return {{2{t[WORD_BITS-1]}}, t[WORD_BITS-1:2]};
   endfunction

   function automatic quat_type neg_quat(input quat_type x);
      quat_type z;
      for (int n = 0; n < 4; n++) z[n] = '0 - x[n];
      return z;
   endfunction

   // right multiply by the unit 1, i, j or k
   function automatic quat_type mul_unit(input quat_type x, input logic [1:0] u);
      quat_type z;
      case (u)
         2'd1:    z = {'0 - x[2], x[3], x[0], '0 - x[1]};
         2'd2:    z = {x[1], x[0], '0 - x[3], '0 - x[2]};
         2'd3:    z = {x[0], '0 - x[1], x[2], '0 - x[3]};
         default: z = x;
      endcase
      return z;
   endfunction

endpackage

// ===== src/hqg_mul.sv =====
// hqg_mul: shared 64 by 64 bit multiplier, low word kept, one 16-bit digit a cycle
// depends on hqg_pkg
module hqg_mul (
   input  logic                clock,
   input  logic                reset,
   input  hqg_pkg::mul_req_type req,
   output hqg_pkg::mul_rsp_type rsp
);
   import hqg_pkg::*;

   localparam int DIGIT_BITS = 16;
   localparam int STEPS      = WORD_BITS / DIGIT_BITS;
   localparam int CNT_BITS   = $clog2(STEPS);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   word_type                      mc_ff, mc_in;
   word_type                      mp_ff, mp_in;
   word_type                      acc_ff, acc_in;
   logic [WORD_BITS+DIGIT_BITS-1:0] part;

   assign part = mc_ff * mp_ff[DIGIT_BITS-1:0];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         mc_in  = req.a;
         mp_in  = req.b;
         acc_in = '0;
      end else if (run_ff) begin
         acc_in = acc_ff + part[WORD_BITS-1:0];
         mc_in  = mc_ff << DIGIT_BITS;
         mp_in  = mp_ff >> DIGIT_BITS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// ===== src/hqg_div.sv =====
// hqg_div: shared signed 64-bit divider, radix 2 restoring, truncating toward zero
// depends on hqg_pkg
module hqg_div (
   input  logic                clock,
   input  logic                reset,
   input  hqg_pkg::div_req_type req,
   output hqg_pkg::div_rsp_type rsp
);
   import hqg_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                run_ff, run_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WORD_BITS:0]  r_ff, r_in;
   word_type            q_ff, q_in;
   word_type            d_ff, d_in;
   logic                sq_ff, sq_in;
   logic                sr_ff, sr_in;
   word_type            quo_ff, quo_in;
   word_type            rem_ff, rem_in;
   logic [WORD_BITS:0]  trial;
   logic                fits;

   assign trial = {r_ff[WORD_BITS-1:0], q_ff[WORD_BITS-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      sq_in   = sq_ff;
      sr_in   = sr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         r_in   = '0;
         q_in   = req.num[WORD_BITS-1] ? '0 - req.num : req.num;
         d_in   = req.den[WORD_BITS-1] ? '0 - req.den : req.den;
         sq_in  = req.num[WORD_BITS-1] ^ req.den[WORD_BITS-1];
         sr_in  = req.num[WORD_BITS-1];
      end else if (run_ff) begin
         r_in   = fits ? trial - {1'b0, d_ff} : trial;
         q_in   = {q_ff[WORD_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         quo_in  = sq_ff ? '0 - q_ff : q_ff;
         rem_in  = sr_ff ? '0 - r_ff[WORD_BITS-1:0] : r_ff[WORD_BITS-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      sr_ff  <= sr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== src/hurwitz_quaternion_gcd_unit.sv =====
// hurwitz_quaternion_gcd_unit: top level, sequencer over the shared multiplier and divider
// depends on hqg_pkg, hqg_mul and hqg_div
//
// One word is taken when start is high and busy is low; busy then stays high until the
// result has been shown. The result is on rsp_data for exactly one cycle with rsp_strobe
// high, and the receiver cannot stall it. Every multiply goes through one multiplier that
// takes a 16-bit digit a cycle, so a quaternion product is sixteen multiplies and a norm
// four; every division goes through one 64-step radix 2 divider. A quotient takes one
// product, one norm and eight divisions, and a gcld one norm, one quotient and one product
// per Euclid round, the number of rounds growing with the logarithm of the norms and capped
// at 64, plus the final associate choice.
module hurwitz_quaternion_gcd_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hqg_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hqg_pkg::rsp_type rsp_data
);
   import hqg_pkg::*;

   typedef enum logic [28:0] {
      S_IDLE        = 29'h0000001,
      S_DISPATCH    = 29'h0000002,
      S_PM_ISSUE    = 29'h0000004,
      S_PM_WAIT     = 29'h0000008,
      S_PM_FIN      = 29'h0000010,
      S_P0_DONE     = 29'h0000020,
      S_Q_PROD_SET  = 29'h0000040,
      S_Q_NORM_SET  = 29'h0000080,
      S_Q_CHECK     = 29'h0000100,
      S_Q_MOD_ISSUE = 29'h0000200,
      S_Q_MOD_WAIT  = 29'h0000400,
      S_Q_ADJ       = 29'h0000800,
      S_Q_SIGN      = 29'h0001000,
      S_Q_ROUND     = 29'h0002000,
      S_Q_DIV_ISSUE = 29'h0004000,
      S_Q_DIV_WAIT  = 29'h0008000,
      S_Q_DONE      = 29'h0010000,
      S_G_NORM_SET  = 29'h0020000,
      S_G_TEST      = 29'h0040000,
      S_G_STEP_SET  = 29'h0080000,
      S_G_UPDATE    = 29'h0100000,
      S_N_TSET      = 29'h0200000,
      S_N_TSTORE    = 29'h0400000,
      S_N_NORM_SET  = 29'h0800000,
      S_N_BRANCH    = 29'h1000000,
      S_N_EVEN1     = 29'h2000000,
      S_N_EVEN2     = 29'h4000000,
      S_N_ODD       = 29'h8000000,
      S_N_SIGN      = 29'h10000000
   } state_type;

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;
   logic [1:0]       op_ff, op_in;
   quat_type         x_ff, x_in;
   quat_type         y_ff, y_in;
   quat_type         p_ff, p_in;
   quat_type         q_ff, q_in;
   quat_type         rem_ff, rem_in;
   quat_type         acc_ff, acc_in;
   quat_type         opa_ff, opa_in;
   quat_type         opb_ff, opb_in;
   quat_type         prod_ff, prod_in;
   word_type         nr_ff, nr_in;
   word_type         ny_ff, ny_in;
   word_type         m_ff, m_in;
   word_type         s_ff, s_in;
   logic             conj_ff, conj_in;
   logic             norm_ff, norm_in;
   logic             one_ff, one_in;
   logic             zdiv_ff, zdiv_in;
   logic [3:0]       idx_ff, idx_in;
   logic [1:0]       n_ff, n_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   rsp_type          res_ff, res_in;
   logic             strobe_ff, strobe_in;

   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   term_type         term;
   logic             term_neg;
   logic             last_term;
   word_type         cur_rem;
   word_type         rem_two;
   quat_type         tq;
   quat_type         nx;
   logic [1:0]       ev_i;
   logic [1:0]       ev_nxt;
   logic [1:0]       odd_sel;
   logic             odd_hit;

   function automatic rsp_type pack_rsp(input quat_type w, input logic st);
      rsp_type r;
      r.res_real = w[0][OUT_BITS-1:0];
      r.res_i    = w[1][OUT_BITS-1:0];
      r.res_j    = w[2][OUT_BITS-1:0];
      r.res_k    = w[3][OUT_BITS-1:0];
      r.status   = st;
      return r;
   endfunction

   function automatic word_type sext(input logic [COORD_BITS-1:0] c);
      return {{(WORD_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
   endfunction

   hqg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   hqg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // term selection for the product and norm engine
   always_comb begin
      if (norm_ff) begin
         term = '{ai: idx_ff[1:0], bi: idx_ff[1:0], zi: 2'd0, neg: 1'b0};
      end else begin
         term = prod_term(idx_ff);
      end
      term_neg  = term.neg ^ (conj_ff && (term.ai != 2'd0));
      last_term = norm_ff ? (idx_ff == 4'd3) : (idx_ff == 4'd15);
   end

   assign mul_req.start = (state_ff == S_PM_ISSUE);
   assign mul_req.a     = opa_ff[term.ai];
   assign mul_req.b     = norm_ff ? opa_ff[term.ai] : opb_ff[term.bi];

   assign div_req.start = (state_ff == S_Q_MOD_ISSUE) || (state_ff == S_Q_DIV_ISSUE);
   assign div_req.num   = (state_ff == S_Q_DIV_ISSUE) ? p_ff[n_ff] - rem_ff[n_ff] : p_ff[n_ff];
   assign div_req.den   = (state_ff == S_Q_DIV_ISSUE) ? ny_ff : m_ff;

   assign cur_rem = rem_ff[n_ff];
   assign rem_two = cur_rem << 1;
   assign nx      = neg_quat(x_ff);

   // conjugate reduced mod 4 into 0, 1, 2, -1
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         logic [1:0] md;
         md = (n == 0) ? x_ff[n][1:0] : 2'(2'd0 - x_ff[n][1:0]);
         tq[n] = (md == 2'b11) ? '1 : {{(WORD_BITS-2){1'b0}}, md};
      end
   end

   always_comb begin
      ev_i = n_ff + 2'd1;
      case (n_ff)
         2'd0:    ev_nxt = 2'd2;
         2'd1:    ev_nxt = 2'd3;
         default: ev_nxt = 2'd1;
      endcase
   end

   always_comb begin
      odd_hit = 1'b0;
      odd_sel = 2'd0;
      for (int k = 0; k < 4; k++) begin
         if (!odd_hit && ((x_ff[k][1:0] == 2'b00) != one_ff)) begin
            odd_hit = 1'b1;
            odd_sel = 2'(k);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      prod_in   = prod_ff;
      nr_in     = nr_ff;
      ny_in     = ny_ff;
      m_in      = m_ff;
      s_in      = s_ff;
      conj_in   = conj_ff;
      norm_in   = norm_ff;
      one_in    = one_ff;
      zdiv_in   = zdiv_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      round_in  = round_ff;
      res_in    = res_ff;
      strobe_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.operation;
               x_in     = {sext(req_data.a_k), sext(req_data.a_j),
                           sext(req_data.a_i), sext(req_data.a_real)};
               y_in     = {sext(req_data.b_k), sext(req_data.b_j),
                           sext(req_data.b_i), sext(req_data.b_real)};
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (op_ff == OP_PRODUCT) begin
               opa_in   = x_ff;
               opb_in   = y_ff;
               conj_in  = 1'b0;
               norm_in  = 1'b0;
               idx_in   = '0;
               acc_in   = '0;
               ret_in   = S_P0_DONE;
               state_in = S_PM_ISSUE;
            end else if (op_ff == OP_QUOTIENT) begin
               state_in = S_Q_PROD_SET;
            end else if (op_ff == OP_GCLD) begin
               round_in = '0;
               state_in = S_G_NORM_SET;
            end else begin
               res_in    = pack_rsp('0, 1'b0);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_PM_ISSUE: begin
            state_in = S_PM_WAIT;
         end
         S_PM_WAIT: begin
            if (mul_rsp.done) begin
               acc_in[term.zi] = term_neg ? acc_ff[term.zi] - mul_rsp.prod
                                          : acc_ff[term.zi] + mul_rsp.prod;
               idx_in   = idx_ff + 4'd1;
               state_in = last_term ? S_PM_FIN : S_PM_ISSUE;
            end
         end
         S_PM_FIN: begin
            if (norm_ff) begin
               nr_in = quarter_trunc(acc_ff[0]);
            end else begin
               for (int n = 0; n < 4; n++) prod_in[n] = half_trunc(acc_ff[n]);
            end
            state_in = ret_ff;
         end
         S_P0_DONE: begin
            res_in    = pack_rsp(prod_ff, 1'b0);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         S_Q_PROD_SET: begin
            opa_in   = y_ff;
            opb_in   = x_ff;
            conj_in  = 1'b1;
            norm_in  = 1'b0;
            idx_in   = '0;
            acc_in   = '0;
            ret_in   = S_Q_NORM_SET;
            state_in = S_PM_ISSUE;
         end
         S_Q_NORM_SET: begin
            p_in     = prod_ff;
            opa_in   = y_ff;
            conj_in  = 1'b0;
            norm_in  = 1'b1;
            idx_in   = '0;
            acc_in   = '0;
            ret_in   = S_Q_CHECK;
            state_in = S_PM_ISSUE;
         end
         S_Q_CHECK: begin
            ny_in = nr_ff;
            m_in  = nr_ff << 1;
            s_in  = '0;
            n_in  = '0;
            if ($signed(nr_ff) <= 0) begin
               q_in     = '0;
               zdiv_in  = 1'b1;
               state_in = S_Q_DONE;
            end else begin
               zdiv_in  = 1'b0;
               state_in = S_Q_MOD_ISSUE;
            end
         end
         S_Q_MOD_ISSUE: begin
            state_in = S_Q_MOD_WAIT;
         end
         S_Q_MOD_WAIT: begin
            if (div_rsp.done) begin
               rem_in[n_ff] = div_rsp.rem[WORD_BITS-1] ? div_rsp.rem + m_ff : div_rsp.rem;
               state_in     = S_Q_ADJ;
            end
         end
         S_Q_ADJ: begin
            if ($signed(cur_rem) > $signed(ny_ff)) rem_in[n_ff] = cur_rem - m_ff;
            state_in = S_Q_SIGN;
         end
         S_Q_SIGN: begin
            // sign of rem squared against its rounding partner
            if ($signed(cur_rem) > 0) begin
               s_in = s_ff + (rem_two - ny_ff);
            end else begin
               s_in = s_ff - (rem_two + ny_ff);
            end
            n_in     = n_ff + 2'd1;
            state_in = (n_ff == 2'd3) ? S_Q_ROUND : S_Q_MOD_ISSUE;
         end
         S_Q_ROUND: begin
            if ($signed(s_ff) > 0) begin
               for (int n = 0; n < 4; n++) begin
                  rem_in[n] = ($signed(rem_ff[n]) > 0) ? rem_ff[n] - ny_ff : rem_ff[n] + ny_ff;
               end
            end
            n_in     = '0;
            state_in = S_Q_DIV_ISSUE;
         end
         S_Q_DIV_ISSUE: begin
            state_in = S_Q_DIV_WAIT;
         end
         S_Q_DIV_WAIT: begin
            if (div_rsp.done) begin
               q_in[n_ff] = div_rsp.quo;
               n_in       = n_ff + 2'd1;
               state_in   = (n_ff == 2'd3) ? S_Q_DONE : S_Q_DIV_ISSUE;
            end
         end
         S_Q_DONE: begin
            if (op_ff == OP_GCLD) begin
               state_in = S_G_STEP_SET;
            end else begin
               res_in    = pack_rsp(q_ff, zdiv_ff);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_G_NORM_SET: begin
            opa_in   = y_ff;
            conj_in  = 1'b0;
            norm_in  = 1'b1;
            idx_in   = '0;
            acc_in   = '0;
            ret_in   = S_G_TEST;
            state_in = S_PM_ISSUE;
         end
         S_G_TEST: begin
            if ((nr_ff == '0) || (round_ff == ROUND_BITS'(EUCLID_ROUNDS))) begin
               state_in = S_N_TSET;
            end else begin
               state_in = S_Q_PROD_SET;
            end
         end
         S_G_STEP_SET: begin
            opa_in   = y_ff;
            opb_in   = q_ff;
            conj_in  = 1'b0;
            norm_in  = 1'b0;
            idx_in   = '0;
            acc_in   = '0;
            ret_in   = S_G_UPDATE;
            state_in = S_PM_ISSUE;
         end
         S_G_UPDATE: begin
            x_in = y_ff;
            for (int n = 0; n < 4; n++) y_in[n] = x_ff[n] - prod_ff[n];
            round_in = round_ff + 1'b1;
            state_in = S_G_NORM_SET;
         end
         S_N_TSET: begin
            if (x_ff[0][0]) begin
               opa_in   = x_ff;
               opb_in   = tq;
               conj_in  = 1'b0;
               norm_in  = 1'b0;
               idx_in   = '0;
               acc_in   = '0;
               ret_in   = S_N_TSTORE;
               state_in = S_PM_ISSUE;
            end else begin
               state_in = S_N_NORM_SET;
            end
         end
         S_N_TSTORE: begin
            x_in     = prod_ff;
            state_in = S_N_NORM_SET;
         end
         S_N_NORM_SET: begin
            opa_in   = x_ff;
            conj_in  = 1'b0;
            norm_in  = 1'b1;
            idx_in   = '0;
            acc_in   = '0;
            ret_in   = S_N_BRANCH;
            state_in = S_PM_ISSUE;
         end
         S_N_BRANCH: begin
            n_in = '0;
            if (!nr_ff[0]) begin
               if (x_ff[0][WORD_BITS-1]) x_in = nx;
               state_in = S_N_EVEN1;
            end else begin
               one_in   = (nr_ff[1:0] == 2'b01) && !nr_ff[WORD_BITS-1];
               state_in = S_N_ODD;
            end
         end
         S_N_EVEN1: begin
            if (x_ff[ev_i][WORD_BITS-1] && ($signed(x_ff[ev_nxt]) <= 0)) begin
               x_in = mul_unit(x_ff, ev_i);
            end
            if (n_ff == 2'd2) begin
               state_in = S_N_EVEN2;
            end else begin
               n_in = n_ff + 2'd1;
            end
         end
         S_N_EVEN2: begin
            if (x_ff[ev_i][WORD_BITS-1]) x_in = mul_unit(x_ff, ev_i);
            if (n_ff == 2'd0) begin
               res_in    = pack_rsp(x_in, 1'b0);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               n_in = n_ff - 2'd1;
            end
         end
         S_N_ODD: begin
            if (odd_hit) x_in = mul_unit(x_ff, odd_sel);
            state_in = S_N_SIGN;
         end
         S_N_SIGN: begin
            if (x_ff[0][WORD_BITS-1] || ((x_ff[0] == '0) && x_ff[1][WORD_BITS-1])) begin
               res_in = pack_rsp(nx, 1'b0);
            end else begin
               res_in = pack_rsp(x_ff, 1'b0);
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      prod_ff  <= prod_in;
      nr_ff    <= nr_in;
      ny_ff    <= ny_in;
      m_ff     <= m_in;
      s_ff     <= s_in;
      conj_ff  <= conj_in;
      norm_ff  <= norm_in;
      one_ff   <= one_in;
      zdiv_ff  <= zdiv_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      round_ff <= round_in;
      res_ff   <= res_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = res_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status |-> (rsp_data.res_real == '0) && (rsp_data.res_i == '0)
         && (rsp_data.res_j == '0) && (rsp_data.res_k == '0))
      else $error("zero divisor status with non-zero result");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_PM_WAIT))
      else $error("multiplier finished outside its wait state");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_Q_MOD_WAIT) || (state_ff == S_Q_DIV_WAIT))
      else $error("divider finished outside its wait states");

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for hurwitz_quaternion_gcd_unit (product, nearest quotient, gcld)
// depends on hqg_pkg and the unit; predicts each result word in 64-bit wrapping arithmetic
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hqg_pkg::*;

   localparam int NUM_RANDOM  = 950;
   localparam int STALL_LIMIT = 400000;

   typedef longint quat4_type [0:3];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_results[$];
   int      error_count = 0;
   int      words_sent = 0;
   int      quiet_cycles = 0;

   hurwitz_quaternion_gcd_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic quat4_type quat_of(input longint r, input longint i, input longint j,
                                         input longint k);
      quat4_type z;
      z[0] = r; z[1] = i; z[2] = j; z[3] = k;
      return z;
   endfunction

   function automatic quat4_type hurwitz_mul(input quat4_type a, input quat4_type b);
      quat4_type z;
      z[0] = (a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) / 2;
      z[1] = (a[0]*b[1] + a[1]*b[0] + (a[2]*b[3] - a[3]*b[2])) / 2;
      z[2] = (a[0]*b[2] + a[2]*b[0] + (a[3]*b[1] - a[1]*b[3])) / 2;
      z[3] = (a[0]*b[3] + a[3]*b[0] + (a[1]*b[2] - a[2]*b[1])) / 2;
      return z;
   endfunction

   function automatic quat4_type conjugate(input quat4_type x);
      quat4_type z;
      z = x;
      for (int n = 1; n < 4; n++) z[n] = 0 - x[n];
      return z;
   endfunction

   function automatic longint norm_of(input quat4_type x);
      longint s;
      s = 0;
      for (int n = 0; n < 4; n++) s = s + x[n]*x[n];
      return s / 4;
   endfunction

   function automatic quat4_type unit_quat(input int n);
      quat4_type u;
      u = quat_of(0, 0, 0, 0);
      u[n & 3] = 2;
      return u;
   endfunction

   function automatic bit nearest_quotient(input quat4_type x, input quat4_type y,
                                           output quat4_type q);
      quat4_type p;
      longint ny, m, s, r2;
      longint rem [0:3];
      p = hurwitz_mul(conjugate(y), x);
      ny = norm_of(y);
      s = 0;
      q = quat_of(0, 0, 0, 0);
      if (ny <= 0) return 1'b0;
      m = ny + ny;
      for (int n = 0; n < 4; n++) begin
         rem[n] = (p[n] % m + m) % m;
         if (rem[n] > ny) rem[n] = rem[n] - m;
         r2 = rem[n] + ny;
         if (r2 > ny) begin
            r2 = r2 - m;
            s = s + (rem[n] + r2);
         end else begin
            s = s - (rem[n] + r2);
         end
      end
      if (s > 0)
         for (int n = 0; n < 4; n++) rem[n] = (rem[n] > 0) ? rem[n] - ny : rem[n] + ny;
      for (int n = 0; n < 4; n++) q[n] = (p[n] - rem[n]) / ny;
      return 1'b1;
   endfunction

   function automatic quat4_type left_divisor(input quat4_type a, input quat4_type b);
      quat4_type x, y, q, z, t;
      longint nm;
      bit one, ok;
      x = a;
      y = b;
      for (int round = 0; round < EUCLID_ROUNDS && norm_of(y) != 0; round++) begin
         ok = nearest_quotient(x, y, q);
         z = hurwitz_mul(y, q);
         for (int n = 0; n < 4; n++) z[n] = x[n] - z[n];
         x = y;
         y = z;
      end
      if (x[0] % 2 != 0) begin
         t = conjugate(x);
         for (int n = 0; n < 4; n++) begin
            t[n] = ((t[n] % 4) + 4) % 4;
            if (t[n] == 3) t[n] = -1;
         end
         x = hurwitz_mul(x, t);
      end
      nm = norm_of(x);
      if (nm % 2 == 0) begin
         if (x[0] < 0) x = hurwitz_mul(x, quat_of(-2, 0, 0, 0));
         for (int n = 0; n < 3; n++)
            if (x[n+1] < 0 && x[(n+1)%3+1] <= 0) x = hurwitz_mul(x, unit_quat(n+1));
         for (int n = 2; n >= 0; n--)
            if (x[n+1] < 0) x = hurwitz_mul(x, unit_quat(n+1));
      end else begin
         one = (nm % 4 == 1);
         for (int n = 0; n < 4; n++) begin
            if ((x[n] % 4 == 0) != one) begin
               x = hurwitz_mul(x, unit_quat(n));
               break;
            end
         end
         if (x[0] < 0 || (x[0] == 0 && x[1] < 0)) x = hurwitz_mul(x, quat_of(-2, 0, 0, 0));
      end
      return x;
   endfunction

   function automatic rsp_type predict_result(input req_type w);
      quat4_type a, b, r;
      rsp_type e;
      a = quat_of(w.a_real, w.a_i, w.a_j, w.a_k);
      b = quat_of(w.b_real, w.b_i, w.b_j, w.b_k);
      r = quat_of(0, 0, 0, 0);
      e = '0;
      case (w.operation)
         OP_PRODUCT:  r = hurwitz_mul(a, b);
         OP_QUOTIENT: e.status = !nearest_quotient(a, b, r);
         OP_GCLD:     r = left_divisor(a, b);
         default:     r = quat_of(0, 0, 0, 0);
      endcase
      e.res_real = r[0][OUT_BITS-1:0];
      e.res_i    = r[1][OUT_BITS-1:0];
      e.res_j    = r[2][OUT_BITS-1:0];
      e.res_k    = r[3][OUT_BITS-1:0];
      return e;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic req_type make_word(input logic [1:0] op, input quat4_type a,
                                         input quat4_type b);
      req_type w;
      w.operation = op;
      w.a_real = COORD_BITS'(a[0]); w.a_i = COORD_BITS'(a[1]);
      w.a_j    = COORD_BITS'(a[2]); w.a_k = COORD_BITS'(a[3]);
      w.b_real = COORD_BITS'(b[0]); w.b_i = COORD_BITS'(b[1]);
      w.b_j    = COORD_BITS'(b[2]); w.b_k = COORD_BITS'(b[3]);
      return w;
   endfunction

   // coordinates bounded by bound, or over the full 24-bit field when bound is 0, mostly all of one parity
   function automatic quat4_type random_quat(input int bound, input bit mixed);
      quat4_type z;
      int par, v;
      par = $urandom_range(0, 1);
      for (int n = 0; n < 4; n++) begin
         if (bound == 0) begin
            v = $signed($urandom()) >>> 8;
         end else begin
            v = int'($urandom_range(0, 2*bound)) - bound;
         end
         if (mixed) par = $urandom_range(0, 1);
         z[n] = (v & ~1) | par;
      end
      return z;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_results.push_back(predict_result(req_data));
         if (!start || !busy) begin
            if (pending_words.size() > 0 &&
                ((words_sent > 300 && words_sent < 450) || $urandom_range(0, 99) >= 34)) begin
               start    <= 1'b1;
               req_data <= pending_words.pop_front();
               words_sent++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("unexpected result word at %0t", $time);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.res_real !== want.res_real)
               report_mismatch("res_real", rsp_data.res_real, want.res_real);
            if (rsp_data.res_i !== want.res_i)
               report_mismatch("res_i", rsp_data.res_i, want.res_i);
            if (rsp_data.res_j !== want.res_j)
               report_mismatch("res_j", rsp_data.res_j, want.res_j);
            if (rsp_data.res_k !== want.res_k)
               report_mismatch("res_k", rsp_data.res_k, want.res_k);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      quat4_type zq, a, b;
      int op, bound;
      zq = quat_of(0, 0, 0, 0);
      // field extremes, every operation, special cases
      pending_words.push_back(make_word(OP_PRODUCT, quat_of(8388607, 8388607, 8388607, 8388607),
                                        quat_of(-8388608, -8388608, -8388608, -8388608)));
      pending_words.push_back(make_word(OP_PRODUCT, quat_of(-8388608, 8388607, -8388608, 8388607),
                                        quat_of(-8388608, -8388608, 8388607, 8388607)));
      pending_words.push_back(make_word(OP_PRODUCT, quat_of(1, 1, 1, 1), quat_of(1, -1, -1, -1)));
      pending_words.push_back(make_word(OP_QUOTIENT, quat_of(6, 4, 2, 0), zq));
      pending_words.push_back(make_word(OP_QUOTIENT, quat_of(1, 0, 0, 0), quat_of(1, 0, 0, 0)));
      pending_words.push_back(make_word(OP_QUOTIENT, quat_of(2, 2, 0, 0), quat_of(4, 0, 0, 0)));
      pending_words.push_back(make_word(OP_QUOTIENT, quat_of(8388607, -8388608, 8388607, 1),
                                        quat_of(3, 1, -1, 1)));
      pending_words.push_back(make_word(OP_GCLD, zq, zq));
      pending_words.push_back(make_word(OP_GCLD, quat_of(-6, 2, -4, 0), zq));
      pending_words.push_back(make_word(OP_GCLD, zq, quat_of(-3, -1, 1, -1)));
      pending_words.push_back(make_word(OP_GCLD, quat_of(10, 0, 0, 0), quat_of(6, 0, 0, 0)));
      pending_words.push_back(make_word(OP_GCLD, quat_of(5, 3, -1, 1), quat_of(-3, 3, 1, -1)));
      pending_words.push_back(make_word(OP_GCLD, quat_of(0, -2, -2, 0), quat_of(0, 0, -4, -2)));
      pending_words.push_back(make_word(OP_GCLD, quat_of(1, 2, 3, 4), quat_of(2, 3, 5, 7)));
      pending_words.push_back(make_word(OP_GCLD, quat_of(8388607, -8388608, 12345, -777),
                                        quat_of(-8388608, 8388607, 4242, 99)));
      pending_words.push_back(make_word(OP_INVALID, quat_of(5, 5, 5, 5), quat_of(3, 3, 3, 3)));
      for (int n = 0; n < NUM_RANDOM; n++) begin
         op = $urandom_range(0, 31);
         op = (op < 10) ? OP_PRODUCT : (op < 20) ? OP_QUOTIENT : (op < 31) ? OP_GCLD : OP_INVALID;
         if (op == OP_GCLD) bound = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(2, 80);
         else bound = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 200);
         a = random_quat(bound, $urandom_range(0, 9) == 0);
         b = ($urandom_range(0, 29) == 0) ? zq : random_quat(bound, $urandom_range(0, 9) == 0);
         pending_words.push_back(make_word(op[1:0], a, b));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || start || expected_results.size() != 0);
      repeat (2000) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/hqg_pkg.sv
src/hqg_mul.sv
src/hqg_div.sv
src/hurwitz_quaternion_gcd_unit.sv
sim/testbench.sv
